>>> rtl/core/assert_macros.svh
// assertion macros shared by the core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// property checked during reset as well
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/ectt_pkg.sv
// ----------------------------------------------------------------------------
// ectt_pkg
// Shared types and constants of the event coalescing timer table.
// ----------------------------------------------------------------------------
`default_nettype none
package ectt_pkg;

  localparam int unsigned ENTRIES = 16;
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam int unsigned QDEPTH = 2;

  localparam logic [31:0] RESET_REFRESH = 32'd60000;
  localparam logic [31:0] RESET_EXPIRY = 32'd5000;
  localparam logic [15:0] RESET_MIN_ACC = 16'd1;

  localparam logic [1:0] CFG_REFRESH = 2'd0;
  localparam logic [1:0] CFG_EXPIRY = 2'd1;
  localparam logic [1:0] CFG_MIN_ACC = 2'd2;

  localparam logic [1:0] RK_CHECK = 2'd0;
  localparam logic [1:0] RK_EMIT = 2'd1;
  localparam logic [1:0] RK_SWEEP_DONE = 2'd2;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_SWEEP = 1'b1;

  // one queued command from front to back
  typedef struct packed {
    logic        op;
    logic [3:0]  kind;
    logic [31:0] path;
    logic [63:0] modified;
    logic [31:0] now;
  } cmd_t;

  // one result beat
  typedef struct packed {
    logic [1:0]  rkind;
    logic        present;
    logic        full;
    logic [3:0]  kind;
    logic [31:0] path;
    logic [63:0] modified;
    logic        last;
  } res_t;

endpackage
`default_nettype wire

>>> rtl/core/ectt_front.sv
// ----------------------------------------------------------------------------
// ectt_front
// Accepts input beats and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ectt_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire ectt_pkg::cmd_t   in_cmd,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output ectt_pkg::cmd_t        q_cmd
);

  localparam int unsigned PTR_W = $clog2(ectt_pkg::QDEPTH);

  ectt_pkg::cmd_t mem [ectt_pkg::QDEPTH];
  logic [PTR_W-1:0] wptr, rptr;
  logic [PTR_W:0] fill;
  logic push, pop;

  assign in_ready = (fill != PTR_W'(0) + (PTR_W+1)'(ectt_pkg::QDEPTH));
  assign push = in_valid && in_ready;
  assign q_valid = (fill != '0);
  assign pop = q_valid && q_ready;
  assign q_cmd = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      fill <= fill + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  `ASSERT_CLK(a_fill_bound, fill <= (PTR_W+1)'(ectt_pkg::QDEPTH), "queue overfilled")
  `ASSERT_CLK(a_no_pop_empty, pop |-> fill != '0, "pop from empty queue")
  `ASSERT_CLK(a_fill_track, (push && !pop) |=> fill == $past(fill) + 1'b1, "fill count slip")

endmodule
`default_nettype wire

>>> rtl/core/ectt_back.sv
// ----------------------------------------------------------------------------
// ectt_back
// Scans the table one slot per cycle for an access or sweep; stalls on emits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ectt_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [31:0]      refresh_window,
  input  wire logic [31:0]      idle_expiry,
  input  wire logic [15:0]      min_accesses,
  input  wire logic             q_valid,
  output logic                  q_ready,
  input  wire ectt_pkg::cmd_t   q_cmd,
  output logic                  res_valid,
  input  wire logic             res_ready,
  output ectt_pkg::res_t        res
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_ACT  = 4'b0100,
    S_OUT  = 4'b1000
  } state_t;

  state_t state;
  ectt_pkg::cmd_t cur;
  logic [ectt_pkg::IDX_W-1:0] idx, hit_idx, free_idx;
  logic [ectt_pkg::CNT_W-1:0] step;
  logic hit_found, free_found, rd_ok;
  logic [ectt_pkg::ENTRIES-1:0] valid;

  // table memory, one record per slot
  logic [3:0]  m_kind  [ectt_pkg::ENTRIES];
  logic [31:0] m_path  [ectt_pkg::ENTRIES];
  logic [63:0] m_mod   [ectt_pkg::ENTRIES];
  logic [31:0] m_acc   [ectt_pkg::ENTRIES];
  logic [31:0] m_emit  [ectt_pkg::ENTRIES];
  logic [15:0] m_cnt   [ectt_pkg::ENTRIES];

  logic [3:0]  r_kind;
  logic [31:0] r_path, r_acc, r_emit;
  logic [63:0] r_mod;
  logic [15:0] r_cnt;
  logic        r_valid;
  logic [ectt_pkg::IDX_W-1:0] r_idx;

  logic [ectt_pkg::IDX_W-1:0] rd_addr;
  logic wr_en;
  logic [ectt_pkg::IDX_W-1:0] wr_addr;
  logic wr_ins, wr_emit;
  logic [31:0] wr_now;
  logic [15:0] wr_cnt;

  logic expired, emits, hit_here, stale;
  logic [15:0] cnt_inc;
  logic act_go;

  assign q_ready = (state == S_IDLE) && !res_valid;
  assign rd_addr = idx;
  assign act_go = (state == S_ACT) && rd_ok && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    r_kind <= m_kind[rd_addr];
    r_path <= m_path[rd_addr];
    r_mod  <= m_mod[rd_addr];
    r_acc  <= m_acc[rd_addr];
    r_emit <= m_emit[rd_addr];
    r_cnt  <= m_cnt[rd_addr];
    if (wr_en) begin
      m_acc[wr_addr] <= wr_now;
      m_cnt[wr_addr] <= wr_cnt;
      if (wr_emit) m_emit[wr_addr] <= wr_now;
      if (wr_ins) begin
        m_kind[wr_addr] <= cur.kind;
        m_path[wr_addr] <= cur.path;
        m_mod[wr_addr]  <= cur.modified;
      end
    end
  end

  assign hit_here = r_valid && r_kind == cur.kind && r_path == cur.path;
  assign expired = r_valid && ((cur.now - r_acc) > idle_expiry);
  assign emits = expired && r_cnt >= min_accesses && r_kind != '0 && r_path != '0;
  assign stale = (cur.now - r_emit) > refresh_window;
  assign cnt_inc = (r_cnt == 16'hFFFF) ? r_cnt : r_cnt + 16'd1;

  always_comb begin
    wr_en = 1'b0;
    wr_addr = hit_idx;
    wr_ins = 1'b0;
    wr_emit = 1'b0;
    wr_now = cur.now;
    wr_cnt = cnt_inc;
    if (act_go && cur.op == ectt_pkg::OP_ACCESS) begin
      if (hit_found) begin
        wr_en = 1'b1;
        wr_emit = stale;
        wr_cnt = stale ? 16'd0 : cnt_inc;
      end else if (free_found) begin
        wr_en = 1'b1;
        wr_addr = free_idx;
        wr_ins = 1'b1;
        wr_emit = 1'b1;
        wr_cnt = 16'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      res_valid <= 1'b0;
      idx <= '0;
      step <= '0;
      rd_ok <= 1'b0;
      hit_found <= 1'b0;
      free_found <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (q_valid && q_ready) begin
            cur <= q_cmd;
            idx <= '0;
            step <= '0;
            rd_ok <= 1'b0;
            hit_found <= 1'b0;
            free_found <= 1'b0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          // result of the previous read address is now in r_*
          rd_ok <= 1'b0;
          if (rd_ok) begin
            if (cur.op == ectt_pkg::OP_ACCESS) begin
              if (hit_here && !hit_found) begin
                hit_found <= 1'b1;
                hit_idx <= r_idx;
              end
              if (!r_valid && !free_found) begin
                free_found <= 1'b1;
                free_idx <= r_idx;
              end
            end else if (expired) begin
              valid[r_idx] <= 1'b0;
              if (emits) begin
                res <= '{rkind: ectt_pkg::RK_EMIT, present: 1'b0, full: 1'b0,
                         kind: r_kind, path: r_path, modified: r_mod, last: 1'b0};
                res_valid <= 1'b1;
                state <= S_OUT;
              end
            end
          end
          if (state == S_SCAN && !(rd_ok && cur.op == ectt_pkg::OP_SWEEP && emits)) begin
            if (step == ectt_pkg::CNT_W'(ectt_pkg::ENTRIES)) begin
              state <= S_ACT;
              // point the read port at the hit slot for the update
              if (cur.op == ectt_pkg::OP_ACCESS) begin
                if (rd_ok && hit_here && !hit_found) begin
                  idx <= r_idx;
                end else if (hit_found) begin
                  idx <= hit_idx;
                end
              end
            end else begin
              r_idx <= idx;
              r_valid <= valid[idx];
              rd_ok <= 1'b1;
              idx <= idx + 1'b1;
              step <= step + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            state <= S_SCAN;
            if (step == ectt_pkg::CNT_W'(ectt_pkg::ENTRIES)) begin
              state <= S_ACT;
            end else begin
              r_idx <= idx;
              r_valid <= valid[idx];
              rd_ok <= 1'b1;
              idx <= idx + 1'b1;
              step <= step + 1'b1;
            end
          end
        end
        S_ACT: begin
          // wait for the hit slot read to land in r_*
          if (!rd_ok) begin
            rd_ok <= 1'b1;
          end else if (act_go) begin
            if (cur.op == ectt_pkg::OP_ACCESS) begin
              if (!hit_found && free_found) valid[free_idx] <= 1'b1;
              res <= '{rkind: ectt_pkg::RK_CHECK,
                       present: hit_found && !stale,
                       full: !hit_found && !free_found,
                       kind: 4'd0, path: 32'd0, modified: 64'd0, last: 1'b1};
            end else begin
              res <= '{rkind: ectt_pkg::RK_SWEEP_DONE, present: 1'b0, full: 1'b0,
                       kind: 4'd0, path: 32'd0, modified: 64'd0, last: 1'b1};
            end
            res_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_onehot, $onehot(state), "state not one-hot")
  `ASSERT_CLK(a_no_take_busy, (q_valid && q_ready) |-> !res_valid, "command taken with result pending")
  `ASSERT_CLK(a_full_excl, (res_valid && res.full) |-> !res.present, "full and present together")

endmodule
`default_nettype wire

>>> rtl/core/event_coalescing_timer_table_core.sv
// Access: from input accept to result valid the path is queue hand-off, a scan of
// 16 slots through the single table read port, a hit read and an update.
// Sweep: same path plus a wait on each emitted event until it is taken; the back
// holds one item at a time and takes no new one until its result has been taken.
// A two-entry queue lets the next items be taken while the scan runs.
// Synchronous reset clears all slots' valid bits and loads register defaults.
// ----------------------------------------------------------------------------
// event_coalescing_timer_table_core
// Top level: configuration registers, input queue and table scan engine.
// ----------------------------------------------------------------------------
`default_nettype none
module event_coalescing_timer_table_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        opcode,
  input  wire logic [3:0]  event_kind,
  input  wire logic [31:0] path_key,
  input  wire logic [63:0] modified_at,
  input  wire logic [31:0] now_tick,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       result_kind,
  output logic             present_refreshed,
  output logic             table_full,
  output logic [3:0]       out_kind,
  output logic [31:0]      out_path,
  output logic [63:0]      out_modified,
  output logic             last_of_run
);

  logic [31:0] refresh_window, idle_expiry;
  logic [15:0] min_accesses;
  ectt_pkg::cmd_t in_cmd, q_cmd;
  ectt_pkg::res_t res;
  logic q_valid, q_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_window <= ectt_pkg::RESET_REFRESH;
      idle_expiry <= ectt_pkg::RESET_EXPIRY;
      min_accesses <= ectt_pkg::RESET_MIN_ACC;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        ectt_pkg::CFG_REFRESH: refresh_window <= cfg_data;
        ectt_pkg::CFG_EXPIRY:  idle_expiry <= cfg_data;
        ectt_pkg::CFG_MIN_ACC: min_accesses <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_cmd = '{op: opcode, kind: event_kind, path: path_key,
                    modified: modified_at, now: now_tick};

  ectt_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_cmd,
    .q_valid, .q_ready, .q_cmd
  );

  ectt_back u_back (
    .clk, .rst, .refresh_window, .idle_expiry, .min_accesses,
    .q_valid, .q_ready, .q_cmd,
    .res_valid(out_valid), .res_ready(out_ready), .res
  );

  assign result_kind = res.rkind;
  assign present_refreshed = res.present;
  assign table_full = res.full;
  assign out_kind = res.kind;
  assign out_path = res.path;
  assign out_modified = res.modified;
  assign last_of_run = res.last;

endmodule
`default_nettype wire
